### sv/fchpc_pkg.sv
// shared types and constants for the fridge cool/heat predictive controller
`default_nettype none
package fchpc_pkg;

   // mode codes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_COOL = 2'd1;
   localparam logic [1:0] MODE_HEAT = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_IDLE_BAND       = 3'd0;
   localparam logic [2:0] CSR_PEAK_TOLERANCE  = 3'd1;
   localparam logic [2:0] CSR_COOL_MIN_ON_S   = 3'd2;
   localparam logic [2:0] CSR_COOL_MAX_ON_S   = 3'd3;
   localparam logic [2:0] CSR_COOL_MIN_OFF_S  = 3'd4;
   localparam logic [2:0] CSR_HEAT_MIN_OFF_S  = 3'd5;
   localparam logic [2:0] CSR_PEAK_MAX_WAIT_S = 3'd6;
   localparam logic [2:0] CSR_PEAK_MAX_TIME_S = 3'd7;

   // estimator constants, factor in units of 1/256000
   localparam logic [15:0] EST_RESET    = 16'd7680;
   localparam logic [15:0] EST_FLOOR    = 16'd13;
   localparam logic [18:0] FACTOR_ONE   = 19'd256000;
   localparam logic [22:0] FACTOR_MIN   = 23'd307200;
   localparam logic [22:0] FACTOR_MAX   = 23'd384000;
   localparam logic [4:0]  FACTOR_SLOPE = 5'd30;

   // reciprocals for the constant divides
   // x/1000   = ((x >> 3)  * RECIP_MS)   >> 36, for x below 2^32
   // x/3600   = ((x >> 4)  * RECIP_HOUR) >> 36, for x below 2^32
   // x/256000 = ((x >> 11) * RECIP_ONE)  >> 31, for x below 2^35
   localparam logic [29:0] RECIP_MS   = 30'd549755814;
   localparam logic [28:0] RECIP_HOUR = 29'd305419897;
   localparam logic [24:0] RECIP_ONE  = 25'd17179870;

   // divider widths
   localparam int DIV_W = 34;
   localparam int DVS_W = 19;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] filtered_temp;
      logic [15:0] cool_target;
      logic        peak_seen;
      logic [23:0] heat_duty_ms;
      logic        heat_window_done;
   } req_type;

   typedef struct packed {
      logic        cool_relay;
      logic        heat_relay;
      logic [1:0]  current_mode;
      logic        waiting_for_peak;
      logic [15:0] overshoot_rate;
      logic        estimator_saved;
   } rsp_type;

   typedef struct packed {
      logic [11:0] idle_band;
      logic [11:0] peak_tolerance;
      logic [15:0] cool_min_on_s;
      logic [15:0] cool_max_on_s;
      logic [15:0] cool_min_off_s;
      logic [15:0] heat_min_off_s;
      logic [15:0] peak_max_wait_s;
      logic [15:0] peak_max_time_s;
   } cfg_type;

   // classified request as it sits in the queue
   typedef struct packed {
      req_type     item;
      logic        gt_hi;
      logic        lt_lo;
      logic [16:0] lo;
   } work_type;

endpackage
`default_nettype wire

### sv/fchpc_front.sv
// front end: accepts requests and classifies temperature against the band
`default_nettype none
module fchpc_front (
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire fchpc_pkg::req_type req_data,
   input  wire [11:0]             idle_band,
   input  wire                    q_full,
   output logic                   q_push,
   output fchpc_pkg::work_type    q_data
);
   import fchpc_pkg::*;

   logic signed [16:0] temp_x;
   logic signed [16:0] target_x;
   logic signed [16:0] band_x;
   logic signed [16:0] hi;
   logic signed [16:0] lo;

   // band limits around the target
   always_comb begin
      temp_x   = $signed({req_data.filtered_temp[15], req_data.filtered_temp});
      target_x = $signed({req_data.cool_target[15], req_data.cool_target});
      band_x   = $signed({5'b0, idle_band});
      hi       = target_x + band_x;
      lo       = target_x - band_x;
   end

   // handshake into the queue
   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      q_data.item  = req_data;
      q_data.gt_hi = temp_x > hi;
      q_data.lt_lo = temp_x < lo;
      q_data.lo    = lo;
   end

endmodule
`default_nettype wire

### sv/fchpc_queue.sv
// two-entry queue between front and back
`default_nettype none
module fchpc_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire fchpc_pkg::work_type push_data,
   output logic                     full,
   input  wire                      pop,
   output fchpc_pkg::work_type      pop_data,
   output logic                     empty
);
   import fchpc_pkg::*;

   work_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### sv/fchpc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module fchpc_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [fchpc_pkg::DIV_W-1:0]  dividend,
   input  wire [fchpc_pkg::DVS_W-1:0]  divisor,
   output logic                        done,
   output logic [fchpc_pkg::DIV_W-1:0] quotient
);
   import fchpc_pkg::*;

   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] dvs_in;
   logic [5:0]       cnt_ff;
   logic [5:0]       cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // one shift and trial subtract a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

### sv/fchpc_back.sv
// back end: mode sequencer, timing checks, overshoot prediction and retune
`default_nettype none
module fchpc_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire fchpc_pkg::cfg_type  cfg,
   input  wire fchpc_pkg::work_type q_data,
   input  wire                      q_empty,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output fchpc_pkg::rsp_type       rsp_data
);
   import fchpc_pkg::*;

   typedef enum logic [6:0] {
      ST_WAIT = 7'b0000001,
      ST_SEC  = 7'b0000010,
      ST_EVAL = 7'b0000100,
      ST_PRED = 7'b0001000,
      ST_STOP = 7'b0010000,
      ST_RET  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   work_type    cur_ff, cur_in;
   logic [31:0] diff_ff, diff_in;
   logic [31:0] secs_ff, secs_in;
   logic [34:0] wide_ff, wide_in;
   logic [20:0] quo_ff, quo_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  before_ff, before_in;
   logic [15:0] est_ff, est_in;
   logic [15:0] peak_ff, peak_in;
   logic [31:0] run_start_ff, run_start_in;
   logic [31:0] idle_start_ff, idle_start_in;
   logic        heater_ff, heater_in;
   logic        comp_ff, comp_in;
   logic        saved_ff, saved_in;
   logic        neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DVS_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;

   logic [15:0]        run_t;
   logic signed [16:0] err;
   logic [16:0]        mag;
   logic [22:0]        fac_raw;
   logic [18:0]        fac;
   logic [34:0]        prod_up;
   logic [33:0]        prod_down;
   logic [31:0]        prod_pred;
   logic [58:0]        sec_prod;
   logic [56:0]        hour_prod;
   logic [48:0]        up_prod;
   logic [31:0]        run_ms;
   logic signed [33:0] pred;
   logic signed [33:0] lo_x;
   logic [15:0]        pred_sat;

   fchpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // datapath terms for prediction and retune
   always_comb begin
      run_t   = (secs_ff < {16'b0, cfg.peak_max_time_s}) ? secs_ff[15:0]
                                                        : cfg.peak_max_time_s;
      err     = $signed({peak_ff[15], peak_ff})
              - $signed({cur_ff.item.filtered_temp[15], cur_ff.item.filtered_temp});
      mag     = err[16] ? 17'(-err) : 17'(err);
      fac_raw = FACTOR_MIN + (23'(mag) * 23'(FACTOR_SLOPE));
      fac     = (fac_raw > FACTOR_MAX) ? FACTOR_MAX[18:0] : fac_raw[18:0];
      prod_up   = est_ff * fac;
      prod_down = est_ff * FACTOR_ONE;
      prod_pred = run_t * est_ff;
      // constant divides by reciprocal multiply
      sec_prod  = diff_ff[31:3] * RECIP_MS;
      hour_prod = wide_ff[31:4] * RECIP_HOUR;
      up_prod   = wide_ff[34:11] * RECIP_ONE;
      run_ms    = cur_ff.item.now_ms - run_start_ff;
      pred = $signed({{18{cur_ff.item.filtered_temp[15]}}, cur_ff.item.filtered_temp})
           - $signed({13'b0, quo_ff});
      lo_x = $signed({{17{cur_ff.lo[16]}}, cur_ff.lo});
      if (pred < -34'sd32768) begin
         pred_sat = 16'h8000;
      end else if (pred > 34'sd32767) begin
         pred_sat = 16'h7fff;
      end else begin
         pred_sat = pred[15:0];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      diff_in       = diff_ff;
      secs_in       = secs_ff;
      wide_in       = wide_ff;
      quo_in        = quo_ff;
      mode_in       = mode_ff;
      before_in     = before_ff;
      est_in        = est_ff;
      peak_in       = peak_ff;
      run_start_in  = run_start_ff;
      idle_start_in = idle_start_ff;
      heater_in     = heater_ff;
      comp_in       = comp_ff;
      saved_in      = saved_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      case (state_ff)
         ST_WAIT: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               saved_in = 1'b0;
               diff_in  = q_data.item.now_ms
                        - ((mode_ff == MODE_COOL) ? run_start_ff : idle_start_ff);
               state_in = ST_SEC;
            end
         end
         ST_SEC: begin
            // elapsed seconds
            secs_in  = {9'b0, sec_prod[58:36]};
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            case (mode_ff)
               MODE_COOL: begin
                  if (secs_ff >= {16'b0, cfg.cool_min_on_s}) begin
                     if (cur_ff.lt_lo) begin
                        mode_in       = MODE_IDLE;
                        before_in     = MODE_IDLE;
                        comp_in       = 1'b0;
                        idle_start_in = cur_ff.item.now_ms;
                     end else begin
                        wide_in  = {3'b0, prod_pred};
                        state_in = ST_PRED;
                     end
                  end
               end
               MODE_HEAT: begin
                  if (run_ms < {8'b0, cur_ff.item.heat_duty_ms} && !heater_ff) begin
                     heater_in = 1'b1;
                  end else if (run_ms > {8'b0, cur_ff.item.heat_duty_ms} && heater_ff) begin
                     heater_in = 1'b0;
                  end
                  if (cur_ff.item.heat_window_done) begin
                     run_start_in = cur_ff.item.now_ms;
                  end
                  if (cur_ff.gt_hi) begin
                     mode_in       = MODE_IDLE;
                     before_in     = MODE_IDLE;
                     heater_in     = 1'b0;
                     idle_start_in = cur_ff.item.now_ms;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
                  if (before_ff == MODE_IDLE) begin
                     if (cur_ff.gt_hi && secs_ff > {16'b0, cfg.cool_min_off_s}) begin
                        mode_in      = MODE_COOL;
                        comp_in      = 1'b1;
                        run_start_in = cur_ff.item.now_ms;
                     end else if (cur_ff.lt_lo
                                  && secs_ff > {16'b0, cfg.heat_min_off_s}) begin
                        mode_in      = MODE_HEAT;
                        run_start_in = cur_ff.item.now_ms;
                     end
                  end else if (before_ff == MODE_COOL) begin
                     if (cur_ff.item.peak_seen
                         || secs_ff >= {16'b0, cfg.peak_max_wait_s}) begin
                        before_in = MODE_IDLE;
                        if (mag > {5'b0, cfg.peak_tolerance}) begin
                           neg_in = err[16];
                           if (err[16]) begin
                              // decrease: divide by the variable factor
                              div_start    = 1'b1;
                              div_dividend = prod_down;
                              div_divisor  = fac;
                           end else begin
                              wide_in = prod_up;
                           end
                           state_in = ST_RET;
                        end
                     end
                  end
               end
            endcase
         end
         ST_PRED: begin
            // overshoot over the capped run time
            quo_in   = hour_prod[56:36];
            state_in = ST_STOP;
         end
         ST_STOP: begin
            state_in = ST_DONE;
            // prediction stop
            if (pred < lo_x) begin
               peak_in       = pred_sat;
               before_in     = MODE_COOL;
               mode_in       = MODE_IDLE;
               comp_in       = 1'b0;
               idle_start_in = cur_ff.item.now_ms;
            end
            // maximum run time stop wins
            if (secs_ff > {16'b0, cfg.cool_max_on_s}) begin
               mode_in       = MODE_IDLE;
               before_in     = MODE_IDLE;
               comp_in       = 1'b0;
               idle_start_in = cur_ff.item.now_ms;
            end
         end
         ST_RET: begin
            if (neg_ff) begin
               if (div_done) begin
                  state_in = ST_DONE;
                  saved_in = 1'b1;
                  est_in   = (div_quotient < {18'b0, EST_FLOOR}) ? EST_FLOOR
                                                                 : div_quotient[15:0];
               end
            end else begin
               state_in = ST_DONE;
               saved_in = 1'b1;
               est_in   = (up_prod[48:47] != 2'b00) ? 16'hffff : up_prod[46:31];
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.cool_relay       = comp_ff;
               rsp_data_in.heat_relay       = heater_ff;
               rsp_data_in.current_mode     = mode_ff;
               rsp_data_in.waiting_for_peak = (mode_ff == MODE_IDLE)
                                            && (before_ff == MODE_COOL);
               rsp_data_in.overshoot_rate   = est_ff;
               rsp_data_in.estimator_saved  = saved_ff;
               state_in                     = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WAIT;
         mode_ff       <= MODE_IDLE;
         before_ff     <= MODE_IDLE;
         est_ff        <= EST_RESET;
         peak_ff       <= '0;
         run_start_ff  <= '0;
         idle_start_ff <= '0;
         heater_ff     <= 1'b0;
         comp_ff       <= 1'b0;
         saved_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         before_ff     <= before_in;
         est_ff        <= est_in;
         peak_ff       <= peak_in;
         run_start_ff  <= run_start_in;
         idle_start_ff <= idle_start_in;
         heater_ff     <= heater_in;
         comp_ff       <= comp_in;
         saved_ff      <= saved_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      diff_ff     <= diff_in;
      secs_ff     <= secs_in;
      wide_ff     <= wide_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // compressor runs only in cool mode
   a_comp_mode: assert property (@(posedge clock) disable iff (reset)
      comp_ff |-> mode_ff == MODE_COOL)
      else $error("compressor on outside cool mode");

   // heater runs only in heat mode
   a_heat_mode: assert property (@(posedge clock) disable iff (reset)
      heater_ff |-> mode_ff == MODE_HEAT)
      else $error("heater on outside heat mode");

   // estimator never falls below its floor
   a_est_floor: assert property (@(posedge clock) disable iff (reset)
      est_ff >= EST_FLOOR)
      else $error("estimator below floor");

   // estimator changes only in the retune step
   a_est_change: assert property (@(posedge clock) disable iff (reset)
      (est_ff != est_in) |-> (state_ff == ST_RET))
      else $error("estimator changed outside retune");

endmodule
`default_nettype wire

### sv/fridge_cool_heat_predictive_controller_core.sv
// top level: register file, front end, queue and back end
// path: the queue, then back end states wait, seconds, evaluate and done; an overshoot
// prediction adds predict and stop, an estimator retune adds retune, and a decrease waits
// on the bit-serial divide; one request at a time goes through the back end;
// the two-entry queue and the result register let requests and results wait apart
// reset: synchronous, active high; idle mode, estimator 30 C/h, registers to defaults
`default_nettype none
module fridge_cool_heat_predictive_controller_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire fchpc_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output fchpc_pkg::rsp_type      rsp_data,
   input  wire                     csr_write_en,
   input  wire [2:0]               csr_index,
   input  wire [15:0]              csr_wdata
);
   import fchpc_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   work_type push_data;
   work_type pop_data;
   logic     push;
   logic     pop;
   logic     q_full;
   logic     q_empty;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IDLE_BAND:       cfg_in.idle_band       = csr_wdata[11:0];
            CSR_PEAK_TOLERANCE:  cfg_in.peak_tolerance  = csr_wdata[11:0];
            CSR_COOL_MIN_ON_S:   cfg_in.cool_min_on_s   = csr_wdata;
            CSR_COOL_MAX_ON_S:   cfg_in.cool_max_on_s   = csr_wdata;
            CSR_COOL_MIN_OFF_S:  cfg_in.cool_min_off_s  = csr_wdata;
            CSR_HEAT_MIN_OFF_S:  cfg_in.heat_min_off_s  = csr_wdata;
            CSR_PEAK_MAX_WAIT_S: cfg_in.peak_max_wait_s = csr_wdata;
            CSR_PEAK_MAX_TIME_S: cfg_in.peak_max_time_s = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_band       <= 12'd128;
         cfg_ff.peak_tolerance  <= 12'd64;
         cfg_ff.cool_min_on_s   <= 16'd180;
         cfg_ff.cool_max_on_s   <= 16'd7200;
         cfg_ff.cool_min_off_s  <= 16'd600;
         cfg_ff.heat_min_off_s  <= 16'd300;
         cfg_ff.peak_max_wait_s <= 16'd1800;
         cfg_ff.peak_max_time_s <= 16'd1200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fchpc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .idle_band (cfg_ff.idle_band),
      .q_full    (q_full),
      .q_push    (push),
      .q_data    (push_data)
   );

   fchpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   fchpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_data    (pop_data),
      .q_empty   (q_empty),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### sim/fridge_cool_heat_predictive_controller_core_tb.sv
// self-checking testbench for the fridge cool/heat predictive controller core
`timescale 1ns / 100ps
module fridge_cool_heat_predictive_controller_core_tb;
   import fchpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   fridge_cool_heat_predictive_controller_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // request stream and expected responses
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   // controller shadow state
   cfg_type     shadow_cfg;
   logic [1:0]  ctl_mode, ctl_mode_prev;
   logic [15:0] ctl_rate;
   longint      ctl_peak;
   logic [31:0] ctl_run_start, ctl_idle_start;
   logic        ctl_heater, ctl_compressor;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int n_checked = 0, n_retunes = 0, n_cool = 0, n_heat = 0, n_wait = 0;
   int quiet_cycles = 0;

   // one control tick of the controller
   task automatic tick_controller(input req_type r);
      longint temp, hi, lo, run_s, off_s, t, pred, err, mag, f, e;
      logic [31:0] run_ms;
      logic [31:0] elapsed;
      logic saved;
      rsp_type x;
      temp  = longint'($signed(r.filtered_temp));
      hi    = longint'($signed(r.cool_target)) + longint'(shadow_cfg.idle_band);
      lo    = longint'($signed(r.cool_target)) - longint'(shadow_cfg.idle_band);
      saved = 1'b0;
      if (ctl_mode == MODE_COOL) begin
         elapsed = r.now_ms - ctl_run_start;
         run_s = longint'(elapsed) / 1000;
         if (run_s >= shadow_cfg.cool_min_on_s) begin
            if (temp < lo) begin
               ctl_mode = MODE_IDLE; ctl_mode_prev = MODE_IDLE;
               ctl_compressor = 1'b0; ctl_idle_start = r.now_ms;
            end else begin
               t = (run_s < shadow_cfg.peak_max_time_s) ? run_s : shadow_cfg.peak_max_time_s;
               pred = temp - (t * ctl_rate) / 3600;
               if (pred < lo) begin
                  if (pred < -32768) pred = -32768;
                  if (pred > 32767) pred = 32767;
                  ctl_peak = pred;
                  ctl_mode_prev = ctl_mode; ctl_mode = MODE_IDLE;
                  ctl_compressor = 1'b0; ctl_idle_start = r.now_ms;
               end
               // maximum run time overrides the history
               if (run_s > shadow_cfg.cool_max_on_s) begin
                  ctl_mode = MODE_IDLE; ctl_mode_prev = MODE_IDLE;
                  ctl_compressor = 1'b0; ctl_idle_start = r.now_ms;
               end
            end
         end
      end else if (ctl_mode == MODE_HEAT) begin
         run_ms = r.now_ms - ctl_run_start;
         if (run_ms < 32'(r.heat_duty_ms) && !ctl_heater) ctl_heater = 1'b1;
         else if (run_ms > 32'(r.heat_duty_ms) && ctl_heater) ctl_heater = 1'b0;
         if (r.heat_window_done) ctl_run_start = r.now_ms;
         if (temp > hi) begin
            ctl_mode = MODE_IDLE; ctl_mode_prev = MODE_IDLE;
            ctl_heater = 1'b0; ctl_idle_start = r.now_ms;
         end
      end else begin
         ctl_mode = MODE_IDLE;
         elapsed = r.now_ms - ctl_idle_start;
         off_s = longint'(elapsed) / 1000;
         if (ctl_mode_prev == MODE_IDLE) begin
            if (temp > hi && off_s > shadow_cfg.cool_min_off_s) begin
               ctl_mode = MODE_COOL; ctl_compressor = 1'b1; ctl_run_start = r.now_ms;
            end else if (temp < lo && off_s > shadow_cfg.heat_min_off_s) begin
               ctl_mode = MODE_HEAT; ctl_run_start = r.now_ms;
            end
         end else if (ctl_mode_prev == MODE_COOL) begin
            if (r.peak_seen || off_s >= shadow_cfg.peak_max_wait_s) begin
               // retune the overshoot estimator from the peak error
               err = ctl_peak - temp;
               mag = (err < 0) ? -err : err;
               if (mag > shadow_cfg.peak_tolerance) begin
                  f = 307200 + 30 * mag;
                  if (f > 384000) f = 384000;
                  e = longint'(ctl_rate);
                  if (err > 0) begin
                     e = e * f / 256000;
                     if (e > 65535) e = 65535;
                  end else begin
                     e = e * 256000 / f;
                     if (e < 13) e = 13;
                  end
                  ctl_rate = 16'(e);
                  saved = 1'b1;
               end
               ctl_mode_prev = MODE_IDLE;
            end
         end
      end
      x.cool_relay       = ctl_compressor;
      x.heat_relay       = ctl_heater;
      x.current_mode     = ctl_mode;
      x.waiting_for_peak = (ctl_mode == MODE_IDLE && ctl_mode_prev == MODE_COOL);
      x.overshoot_rate   = ctl_rate;
      x.estimator_saved  = saved;
      expected_rsps.push_back(x);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) tick_controller(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.cool_relay !== want.cool_relay) begin
               $error("cool_relay: expected %0d, got %0d", want.cool_relay, rsp_data.cool_relay);
               errors++;
            end
            if (rsp_data.heat_relay !== want.heat_relay) begin
               $error("heat_relay: expected %0d, got %0d", want.heat_relay, rsp_data.heat_relay);
               errors++;
            end
            if (rsp_data.current_mode !== want.current_mode) begin
               $error("current_mode: expected %0d, got %0d",
                      want.current_mode, rsp_data.current_mode);
               errors++;
            end
            if (rsp_data.waiting_for_peak !== want.waiting_for_peak) begin
               $error("waiting_for_peak: expected %0d, got %0d",
                      want.waiting_for_peak, rsp_data.waiting_for_peak);
               errors++;
            end
            if (rsp_data.overshoot_rate !== want.overshoot_rate) begin
               $error("overshoot_rate: expected %0d, got %0d",
                      want.overshoot_rate, rsp_data.overshoot_rate);
               errors++;
            end
            if (rsp_data.estimator_saved !== want.estimator_saved) begin
               $error("estimator_saved: expected %0d, got %0d",
                      want.estimator_saved, rsp_data.estimator_saved);
               errors++;
            end
            n_checked++;
            if (want.estimator_saved) n_retunes++;
            if (want.current_mode == MODE_COOL) n_cool++;
            if (want.current_mode == MODE_HEAT) n_heat++;
            if (want.waiting_for_peak) n_wait++;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus generation state
   logic [31:0] sim_now = 32'd0;
   int          sim_target = 0;

   task automatic push_req(input logic [31:0] now, input int temp, input int target,
                           input logic peak, input logic [23:0] duty, input logic done);
      req_type r;
      r.now_ms = now; r.filtered_temp = 16'(temp); r.cool_target = 16'(target);
      r.peak_seen = peak; r.heat_duty_ms = duty; r.heat_window_done = done;
      pending_reqs.push_back(r);
   endtask

   // mostly a plausible tick (time moves on, temperature wanders around the target), else random bits
   task automatic push_tick();
      int band, temp, roll;
      logic [95:0] raw;
      req_type r;
      roll = $urandom_range(99);
      if (roll < 8) begin
         raw = {$urandom, $urandom, $urandom};
         r = raw[$bits(req_type)-1:0];
         pending_reqs.push_back(r);
         return;
      end
      band = int'(shadow_cfg.idle_band);
      if (roll < 12) sim_now = sim_now + $urandom;
      else if (roll < 40) sim_now = sim_now + $urandom_range(3000);
      else sim_now = sim_now + $urandom_range(400000);
      if ($urandom_range(19) == 0) sim_target = $urandom_range(4000) - 2000;
      temp = sim_target + $urandom_range(2 * band + 800) - band - 400;
      push_req(sim_now, temp, sim_target, ($urandom_range(3) == 0),
               ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(300000)),
               ($urandom_range(3) == 0));
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all eight registers, idle block only
   task automatic load_regs(input logic [15:0] v[8]);
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= 3'(i);
         csr_wdata    <= v[i];
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
      shadow_cfg.idle_band       = v[CSR_IDLE_BAND][11:0];
      shadow_cfg.peak_tolerance  = v[CSR_PEAK_TOLERANCE][11:0];
      shadow_cfg.cool_min_on_s   = v[CSR_COOL_MIN_ON_S];
      shadow_cfg.cool_max_on_s   = v[CSR_COOL_MAX_ON_S];
      shadow_cfg.cool_min_off_s  = v[CSR_COOL_MIN_OFF_S];
      shadow_cfg.heat_min_off_s  = v[CSR_HEAT_MIN_OFF_S];
      shadow_cfg.peak_max_wait_s = v[CSR_PEAK_MAX_WAIT_S];
      shadow_cfg.peak_max_time_s = v[CSR_PEAK_MAX_TIME_S];
   endtask

   initial begin
      logic [15:0] regs[8];
      shadow_cfg = '{idle_band: 12'd128, peak_tolerance: 12'd64, cool_min_on_s: 16'd180,
                     cool_max_on_s: 16'd7200, cool_min_off_s: 16'd600,
                     heat_min_off_s: 16'd300, peak_max_wait_s: 16'd1800,
                     peak_max_time_s: 16'd1200};
      ctl_mode = MODE_IDLE; ctl_mode_prev = MODE_IDLE; ctl_rate = EST_RESET;
      ctl_peak = 0; ctl_run_start = '0; ctl_idle_start = '0;
      ctl_heater = 1'b0; ctl_compressor = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, a cool run and a heat run
      send_idle_pct = 20; recv_idle_pct = 83;
      push_req(32'd0, 32767, -32768, 1'b1, 24'hFFFFFF, 1'b1);
      push_req(32'hFFFF_FFFF, -32768, 32767, 1'b0, 24'd0, 1'b0);
      push_req(32'd700000, 1000, 0, 1'b0, 24'd0, 1'b0);
      push_req(32'd900000, 500, 0, 1'b0, 24'd0, 1'b0);
      push_req(32'd1500000, 200, 0, 1'b0, 24'd0, 1'b0);
      push_req(32'd1600000, -100, 0, 1'b1, 24'd0, 1'b0);
      push_req(32'd3500000, -300, 0, 1'b0, 24'd0, 1'b0);
      push_req(32'd3600000, -300, 0, 1'b0, 24'd5000, 1'b0);
      push_req(32'd3603000, -300, 0, 1'b0, 24'd5000, 1'b0);
      push_req(32'd3605000, -300, 0, 1'b0, 24'd5000, 1'b0);
      push_req(32'd3607000, -300, 0, 1'b0, 24'd5000, 1'b1);
      push_req(32'd3609000, -300, 0, 1'b0, 24'd5000, 1'b0);
      push_req(32'd3620000, 32767, 0, 1'b0, 24'hFFFFFF, 1'b0);
      push_req(32'hFFFF_F000, 32767, -32768, 1'b0, 24'd0, 1'b0);
      push_req(32'h0000_2000, 32767, -32768, 1'b1, 24'd0, 1'b0);
      push_req(32'h7FFF_FFFF, -32768, 32767, 1'b1, 24'h800000, 1'b1);
      sim_now = 32'h8000_0000;
      for (int i = 0; i < 100; i++) push_tick();
      wait_idle();

      // register settings, extremes among them; idling pattern rotates per phase
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: regs = '{16'd128, 16'd64, 16'd0, 16'd600, 16'd0, 16'd0, 16'd300, 16'd1200};
            1: regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            2: regs = '{16'd2560, 16'd2560, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF};
            3: regs = '{16'd0, 16'd0, 16'd30, 16'hFFFF, 16'd60, 16'd60, 16'hFFFF, 16'hFFFF};
            4: regs = '{16'hFFFF, 16'hF000, 16'd100, 16'd900, 16'd120, 16'd120,
                        16'd600, 16'd0};
            default: regs = '{16'($urandom_range(400)), 16'($urandom_range(200)),
                              16'($urandom_range(300)), 16'($urandom_range(3000)),
                              16'($urandom_range(600)), 16'($urandom_range(600)),
                              16'($urandom_range(2000)), 16'($urandom_range(3000))};
         endcase
         case (phase % 3)
            0: begin send_idle_pct = 83; recv_idle_pct = 20; end
            1: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            default: begin send_idle_pct = 20; recv_idle_pct = 83; end
         endcase
         load_regs(regs);
         for (int i = 0; i < 90; i++) push_tick();
         wait_idle();
      end

      $display("checked %0d responses: %0d cooling, %0d heating, %0d waiting for peak",
               n_checked, n_cool, n_heat, n_wait);
      $display("estimator retuned %0d times over seven register settings", n_retunes);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/fchpc_pkg.sv
sv/fchpc_front.sv
sv/fchpc_queue.sv
sv/fchpc_div.sv
sv/fchpc_back.sv
sv/fridge_cool_heat_predictive_controller_core.sv
sim/fridge_cool_heat_predictive_controller_core_tb.sv
